// ===== src/iis_pkg.sv =====
`default_nettype none
package iis_pkg;

    localparam int CFG_W      = 13;
    localparam int PIX_W      = 8;
    localparam int AREA_W     = 32;
    localparam int SQ_W       = 40;
    localparam int STORE_SQ_W = 41;
    localparam int ROW_W      = 20;
    localparam int ROW_SQ_W   = 28;
    localparam int N_W        = 26;
    localparam int STAT_W     = 16;
    localparam int ACC_W      = 64;
    localparam int DIV_W      = 80;
    localparam int REM_W      = 27;
    localparam int DIV_STEPS  = 80;
    localparam int SQRT_W     = 40;
    localparam int SQRT_STEPS = 20;
    localparam int CNT_W      = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W       = 2;

    localparam logic [STAT_W-1:0] STD_ONE   = 16'd256;
    localparam logic [SQRT_W-1:0] SQRT_TOP  = {2'b01, 38'd0};

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic              start;
        logic              ack;
        logic [AREA_W-1:0] s;
        logic [SQ_W-1:0]   q;
    } iis_stat_req_t;

    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] mean;
        logic [STAT_W-1:0] std_dev;
    } iis_stat_rsp_t;

    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/iis_if.sv =====
`default_nettype none
interface iis_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface iis_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] area_sum;
    logic [39:0] area_square_sum;
    logic        frame_end;
    logic [15:0] frame_mean;
    logic [15:0] frame_std_dev;

    modport source (output valid, output area_sum, output area_square_sum,
                    output frame_end, output frame_mean, output frame_std_dev,
                    input ready);
    modport sink (input valid, input area_sum, input area_square_sum,
                  input frame_end, input frame_mean, input frame_std_dev,
                  output ready);
endinterface
`default_nettype wire

// ===== src/iis_front.sv =====
`default_nettype none
module iis_front
    import iis_pkg::*;
#(
    parameter int CW = 12,
    parameter int RW = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    iis_pixel_if.sink                   pixel_stream,
    input  wire logic                   restart,
    input  wire logic [CFG_W-1:0]       width_eff,
    input  wire logic [CFG_W-1:0]       height_eff,
    input  wire logic                   full,
    output logic                        push,
    output logic [PIX_W+CW+2:0]         item
);

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          col_end, row_end;

    assign col_end = (CFG_W'(col_reg) == width_eff - CFG_W'(1));
    assign row_end = (CFG_W'(row_reg) == height_eff - CFG_W'(1));

    assign pixel_stream.ready = !full;
    assign push = pixel_stream.valid && !full;
    assign item = {pixel_stream.pixel, col_reg, (row_reg == '0), (col_reg == '0),
                   col_end && row_end};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (push)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/iis_queue.sv =====
`default_nettype none
module iis_queue
    import iis_pkg::*;
#(
    parameter int W = 23
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    input  wire logic         pop,
    output logic [W-1:0]      head,
    output logic              full,
    output logic              empty
);

    logic [W-1:0]    slot_reg [QUEUE_DEPTH];
    logic [QA_W-1:0] wr_reg, rd_reg;
    logic [QA_W:0]   cnt_reg;

    assign full  = (cnt_reg == (QA_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QA_W'(1);
            if (pop)
                rd_reg <= rd_reg + QA_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (QA_W+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (QA_W+1)'(1);
        end
    end

endmodule
`default_nettype wire

// ===== src/iis_stats.sv =====
`default_nettype none
module iis_stats
    import iis_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CFG_W-1:0] width_eff,
    input  wire logic [CFG_W-1:0] height_eff,
    input  wire iis_stat_req_t    req,
    output iis_stat_rsp_t         rsp
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_MUL_LO   = 10'b0000000010,
        ST_MUL_HI   = 10'b0000000100,
        ST_SQ       = 10'b0000001000,
        ST_DIFF     = 10'b0000010000,
        ST_DIV_MEAN = 10'b0000100000,
        ST_DIV_T    = 10'b0001000000,
        ST_DIV_V    = 10'b0010000000,
        ST_SQRT     = 10'b0100000000,
        ST_DONE     = 10'b1000000000
    } st_t;

    st_t               state_reg;
    logic [N_W-1:0]    n_reg;
    logic [AREA_W-1:0] s_reg;
    logic [SQ_W-1:0]   q_reg;
    logic [ACC_W-1:0]  acc_reg, ss_reg, d_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SQRT_W-1:0] v_reg, res_reg, bit_reg;
    logic [STAT_W-1:0] mean_reg, std_reg;

    logic [45:0]       prod_lo, prod_hi;
    logic [ACC_W-1:0]  sq_prod;
    logic [REM_W-1:0]  rem_sh, rem_new;
    logic              div_ge;
    logic [DIV_W-1:0]  dvd_new;
    logic              div_last;
    logic [SQRT_W-1:0] sq_sum, v_new, res_new;
    logic              sq_ge;

    assign prod_lo = n_reg * q_reg[19:0];
    assign prod_hi = n_reg * q_reg[39:20];
    assign sq_prod = s_reg * s_reg;

    assign rem_sh   = {rem_reg[REM_W-2:0], dvd_reg[DIV_W-1]};
    assign div_ge   = rem_sh >= REM_W'(n_reg);
    assign rem_new  = div_ge ? rem_sh - REM_W'(n_reg) : rem_sh;
    assign dvd_new  = {dvd_reg[DIV_W-2:0], div_ge};
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    assign sq_sum  = res_reg + bit_reg;
    assign sq_ge   = v_reg >= sq_sum;
    assign v_new   = sq_ge ? v_reg - sq_sum : v_reg;
    assign res_new = sq_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;

    assign rsp.done    = (state_reg == ST_DONE);
    assign rsp.mean    = mean_reg;
    assign rsp.std_dev = std_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                n_reg <= width_eff * height_eff;
                s_reg <= req.s;
                q_reg <= req.q;
            end
            ST_MUL_LO:
                acc_reg <= ACC_W'(prod_lo);
            ST_MUL_HI:
                acc_reg <= acc_reg + {prod_hi[43:0], 20'd0};
            ST_SQ:
                ss_reg <= sq_prod;
            ST_DIFF:
            begin
                d_reg   <= (acc_reg > ss_reg) ? acc_reg - ss_reg : '0;
                dvd_reg <= {40'd0, s_reg, 8'd0};
                rem_reg <= '0;
            end
            ST_DIV_MEAN, ST_DIV_T, ST_DIV_V:
            begin
                dvd_reg <= dvd_new;
                rem_reg <= rem_new;
                if (div_last)
                begin
                    rem_reg <= '0;
                    if (state_reg == ST_DIV_MEAN)
                    begin
                        mean_reg <= dvd_new[STAT_W-1:0];
                        std_reg  <= STD_ONE;
                        dvd_reg  <= {d_reg, 16'd0};
                    end
                    else if (state_reg == ST_DIV_T)
                    begin
                        dvd_reg <= {24'd0, dvd_new[55:0]};
                    end
                    else
                    begin
                        v_reg   <= dvd_new[SQRT_W-1:0];
                        res_reg <= '0;
                        bit_reg <= SQRT_TOP;
                    end
                end
            end
            ST_SQRT:
            begin
                v_reg   <= v_new;
                res_reg <= res_new;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    std_reg <= res_new[STAT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (req.start)
                        state_reg <= ST_MUL_LO;
                ST_MUL_LO:
                    state_reg <= ST_MUL_HI;
                ST_MUL_HI:
                    state_reg <= ST_SQ;
                ST_SQ:
                    state_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV_MEAN;
                end
                ST_DIV_MEAN, ST_DIV_T, ST_DIV_V:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (div_last)
                    begin
                        cnt_reg <= '0;
                        if (state_reg == ST_DIV_MEAN)
                            state_reg <= (d_reg == '0) ? ST_DONE : ST_DIV_T;
                        else if (state_reg == ST_DIV_T)
                            state_reg <= ST_DIV_V;
                        else
                            state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                    if (req.ack)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/iis_back.sv =====
`default_nettype none
module iis_back
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int CW = 12
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PIX_W+CW+2:0] head,
    input  wire logic               empty,
    output logic                    pop,
    output iis_stat_req_t           stat_req,
    input  wire iis_stat_rsp_t      stat_rsp,
    iis_result_if.source            result_stream
);

    typedef enum logic [2:0] {
        B_FETCH = 3'b001,
        B_CALC  = 3'b010,
        B_STAT  = 3'b100
    } back_state_t;

    back_state_t state_reg;

    logic [AREA_W-1:0]     sum_mem [MAX_WIDTH];
    logic [STORE_SQ_W-1:0] sq_mem  [MAX_WIDTH];

    logic [PIX_W+CW+2:0]   item_reg;
    logic [AREA_W-1:0]     above_reg;
    logic [STORE_SQ_W-1:0] above_sq_reg;
    logic [ROW_W-1:0]      row_sum_reg;
    logic [ROW_SQ_W-1:0]   row_sq_reg;
    logic [AREA_W-1:0]     area_reg;
    logic [SQ_W-1:0]       area_sq_reg;

    logic                  out_valid_reg;
    logic [AREA_W-1:0]     out_area_reg;
    logic [SQ_W-1:0]       out_sq_reg;
    logic                  out_end_reg;
    logic [STAT_W-1:0]     out_mean_reg, out_std_reg;

    logic [PIX_W-1:0]      pix;
    logic [CW-1:0]         col, head_col;
    logic                  first_row, first_col, last;
    logic [ROW_W-1:0]      rs;
    logic [ROW_SQ_W-1:0]   rsq;
    logic [AREA_W-1:0]     area;
    logic [STORE_SQ_W-1:0] area_sq;
    logic                  out_free, calc_go, stat_go;

    assign {pix, col, first_row, first_col, last} = item_reg;
    assign head_col = head[CW+2:3];

    assign out_free = !out_valid_reg || result_stream.ready;
    assign pop      = (state_reg == B_FETCH) && !empty;
    assign calc_go  = (state_reg == B_CALC) && out_free;
    assign stat_go  = (state_reg == B_STAT) && stat_rsp.done && out_free;

    assign rs      = (first_col ? '0 : row_sum_reg) + ROW_W'(pix);
    assign rsq     = (first_col ? '0 : row_sq_reg) + ROW_SQ_W'(pix) * ROW_SQ_W'(pix);
    assign area    = (first_row ? '0 : above_reg) + AREA_W'(rs);
    assign area_sq = (first_row ? '0 : above_sq_reg) + STORE_SQ_W'(rsq);

    assign stat_req.start = calc_go && last;
    assign stat_req.ack   = stat_go;
    assign stat_req.s     = area;
    assign stat_req.q     = area_sq[SQ_W-1:0];

    assign result_stream.valid           = out_valid_reg;
    assign result_stream.area_sum        = out_area_reg;
    assign result_stream.area_square_sum = out_sq_reg;
    assign result_stream.frame_end       = out_end_reg;
    assign result_stream.frame_mean      = out_mean_reg;
    assign result_stream.frame_std_dev   = out_std_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            above_reg    <= sum_mem[head_col];
            above_sq_reg <= sq_mem[head_col];
        end
        if (calc_go)
        begin
            sum_mem[col] <= area;
            sq_mem[col]  <= area_sq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head;
        if (calc_go)
        begin
            row_sum_reg <= rs;
            row_sq_reg  <= rsq;
            area_reg    <= area;
            area_sq_reg <= area_sq[SQ_W-1:0];
        end
        if (calc_go && !last)
        begin
            out_area_reg <= area;
            out_sq_reg   <= area_sq[SQ_W-1:0];
            out_end_reg  <= 1'b0;
            out_mean_reg <= '0;
            out_std_reg  <= '0;
        end
        else if (stat_go)
        begin
            out_area_reg <= area_reg;
            out_sq_reg   <= area_sq_reg;
            out_end_reg  <= 1'b1;
            out_mean_reg <= stat_rsp.mean;
            out_std_reg  <= stat_rsp.std_dev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_FETCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((calc_go && !last) || stat_go)
                out_valid_reg <= 1'b1;
            else if (result_stream.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_FETCH:
                    if (pop)
                        state_reg <= B_CALC;
                B_CALC:
                    if (calc_go)
                        state_reg <= last ? B_STAT : B_FETCH;
                B_STAT:
                    if (stat_go)
                        state_reg <= B_FETCH;
                default:
                    state_reg <= B_FETCH;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/integral_image_with_square_sums.sv =====
// Streaming integral image: for every pixel (raster order) gives the rectangle sum and sum of
// squares from the frame origin; on the last pixel also the frame mean and standard deviation
// in unsigned Q8.8. A front end counts position and queues pixels (4 deep); the back end reads
// the line store, adds and writes back, one pixel at a time, reading in a fetch state and
// writing in a calc state that waits while the output is held. The last pixel of a frame also
// runs the statistics unit: three multiply steps and a subtract, three bit-serial divisions
// and a square root (only the mean division when the variance is zero). Writing frame_width
// (offset 0) or frame_height (offset 4) restarts the frame; 0 is taken as 1 and values above
// MAX_WIDTH/MAX_HEIGHT as the maximum.
`default_nettype none
module integral_image_with_square_sums
    import iis_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    iis_pixel_if.sink        pixel_stream,
    iis_result_if.source     result_stream,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int IW = PIX_W + CW + 3;
    localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H = CFG_W'(MAX_HEIGHT);

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [CFG_W-1:0] width_eff, height_eff;
    logic             wr_en;

    logic             push, pop, full, empty;
    logic [IW-1:0]    item, head;
    iis_stat_req_t    stat_req;
    iis_stat_rsp_t    stat_rsp;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {19'd0, height_reg} : {19'd0, width_reg};

    assign width_eff  = clamp_size(width_reg, MAX_W);
    assign height_eff = clamp_size(height_reg, MAX_H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[CFG_W-1:0];
            else
                height_reg <= pwdata[CFG_W-1:0];
        end
    end

    iis_front #(.CW(CW), .RW(RW)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_stream (pixel_stream),
        .restart      (wr_en),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .full         (full),
        .push         (push),
        .item         (item)
    );

    iis_queue #(.W(IW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (item),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    iis_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .stat_req      (stat_req),
        .stat_rsp      (stat_rsp),
        .result_stream (result_stream)
    );

    iis_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .req        (stat_req),
        .rsp        (stat_rsp)
    );

endmodule
`default_nettype wire

// ===== sim/integral_image_with_square_sums_checker.sv =====
`default_nettype none
module integral_image_with_square_sums_checker
    import iis_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    iis_pixel_if      pixel_stream,
    iis_result_if     result_stream,
    input  wire logic        cfg_we,
    input  wire logic        cfg_sel,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [AREA_W-1:0] area;
        logic [SQ_W-1:0]   area_sq;
        logic              last;
        logic [STAT_W-1:0] mean;
        logic [STAT_W-1:0] std_dev;
    } area_result_t;

    area_result_t      expected_results[$];
    logic [CFG_W-1:0]  width_reg, height_reg;
    logic [ROW_W-1:0]  run_sum;
    logic [ROW_SQ_W-1:0] run_sq;
    logic [AREA_W-1:0] line_sum [4096];
    logic [STORE_SQ_W-1:0] line_sq [4096];
    int unsigned col, row;

    assign pending = expected_results.size();

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic int unsigned fit_size(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > 4096) ? 4096 : v;
    endfunction

    task automatic predict_area(input logic [PIX_W-1:0] p);
        area_result_t e;
        int unsigned w, h;
        logic [AREA_W-1:0] above;
        logic [STORE_SQ_W-1:0] above_sq, sq;
        longint unsigned n, s, q, ns, ss, d, t;
        w = fit_size(width_reg);
        h = fit_size(height_reg);
        if (col >= w || row >= h)
        begin
            col = 0;
            row = 0;
        end
        if (col == 0)
        begin
            run_sum = '0;
            run_sq = '0;
        end
        run_sum = run_sum + p;
        run_sq = run_sq + p * p;
        above = (row == 0) ? '0 : line_sum[col];
        above_sq = (row == 0) ? '0 : line_sq[col];
        e.area = above + run_sum;
        sq = above_sq + run_sq;
        line_sum[col] = e.area;
        line_sq[col] = sq;
        e.area_sq = sq[SQ_W-1:0];
        e.last = (col == w - 1) && (row == h - 1);
        e.mean = '0;
        e.std_dev = '0;
        if (e.last)
        begin
            n = w * h;
            s = e.area;
            q = e.area_sq;
            ns = n * q;
            ss = s * s;
            d = (ns > ss) ? ns - ss : 0;
            e.mean = 16'((s << 8) / n);
            if (d == 0)
                e.std_dev = STD_ONE;
            else
            begin
                t = ((d / n) << 16) + (((d % n) << 16) / n);
                e.std_dev = 16'(root_floor(t / n));
            end
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
        expected_results.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        area_result_t e;
        if (!rst_n)
        begin
            width_reg = 1;
            height_reg = 1;
            run_sum = '0;
            run_sq = '0;
            col = 0;
            row = 0;
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel == REG_HEIGHT)
                    height_reg = cfg_data[CFG_W-1:0];
                else
                    width_reg = cfg_data[CFG_W-1:0];
                col = 0;
                row = 0;
                run_sum = '0;
                run_sq = '0;
            end
            if (pixel_stream.valid && pixel_stream.ready)
                predict_area(pixel_stream.pixel);
            if (result_stream.valid && result_stream.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%t unexpected transfer: got area %0d", $time,
                             result_stream.area_sum);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.area !== result_stream.area_sum
                        || e.area_sq !== result_stream.area_square_sum
                        || e.last !== result_stream.frame_end
                        || e.mean !== result_stream.frame_mean
                        || e.std_dev !== result_stream.frame_std_dev)
                    begin
                        $display("%t mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                                 $time, e.area, e.area_sq, e.last, e.mean, e.std_dev,
                                 result_stream.area_sum, result_stream.area_square_sum,
                                 result_stream.frame_end, result_stream.frame_mean,
                                 result_stream.frame_std_dev);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== sim/integral_image_with_square_sums_tb.sv =====
`default_nettype none
module integral_image_with_square_sums_tb;
    import iis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    int          fail_count, pending;
    logic        pixels_idle_off, long_hold;
    int          frame_pixels, sent;
    logic        pixel_mode;

    iis_pixel_if  pixel_stream ();
    iis_result_if result_stream ();

    integral_image_with_square_sums dut (
        .clk(clk), .rst_n(rst_n), .pixel_stream(pixel_stream.sink),
        .result_stream(result_stream.source), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    integral_image_with_square_sums_checker checker_i (
        .clk(clk), .rst_n(rst_n), .pixel_stream(pixel_stream), .result_stream(result_stream),
        .cfg_we(psel && penable && pwrite && pready), .cfg_sel(paddr[2]), .cfg_data(pwdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off
    initial
    begin
        int n;
        result_stream.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_stream.ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            if (!pixels_idle_off && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 7);
                result_stream.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            result_stream.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic sel, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= sel ? 3'd4 : 3'd0;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] p);
        if (!pixels_idle_off && $urandom_range(0, 5) == 0)
        begin
            pixel_stream.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        pixel_stream.valid <= 1'b1;
        pixel_stream.pixel <= p;
        @(posedge clk);
        while (!pixel_stream.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain;
        pixel_stream.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic logic [7:0] pick_pixel(input int mode);
        case (mode)
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int w, h, total;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        pixel_stream.valid = 0;
        pixel_stream.pixel = 0;
        pixels_idle_off = 0;
        long_hold = 0;
        sent = 0;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        // reset size 1x1: single pixel frames
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd170);
        // zero sizes act as 1, oversize acts as max
        set_frame(0, 0);
        send_pixel(8'd85);
        set_frame(3, 2);
        repeat (6) send_pixel(8'd255);
        repeat (6) send_pixel(8'd0);
        repeat (6) send_pixel(8'd7);
        set_frame(32'h1fff, 1);
        repeat (5) send_pixel(8'd255);
        set_frame(4096, 1);
        for (int i = 0; i < 300; i++)
            send_pixel(8'd255);
        set_frame(1, 4096);
        for (int i = 0; i < 200; i++)
            send_pixel(8'($urandom_range(0, 255)));
        set_frame(2, 2);
        long_hold = 1'b1;
        repeat (40) send_pixel(8'($urandom_range(0, 255)));
        // random frames, most complete, some cut short by a reconfiguration
        total = 0;
        while (total < 1100)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            if (total > 900)
                pixels_idle_off = 1'b1;
            set_frame(w, h);
            frame_pixels = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 7) == 0)
                frame_pixels = $urandom_range(1, w * h);
            pixel_mode = $urandom_range(0, 1);
            for (int i = 0; i < frame_pixels; i++)
                send_pixel(pixel_mode ? pick_pixel($urandom_range(0, 6))
                                      : 8'($urandom_range(0, 255)));
            total += frame_pixels;
        end
        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
src/iis_pkg.sv
src/iis_if.sv
src/iis_front.sv
src/iis_queue.sv
src/iis_stats.sv
src/iis_back.sv
src/integral_image_with_square_sums.sv
sim/integral_image_with_square_sums_checker.sv
sim/integral_image_with_square_sums_tb.sv
